[hdl/bpa_pkg.sv]
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned ORD_W      = 6;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned INFO_W     = 8;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned BIT_ALLOC  = 7;
  localparam int unsigned BIT_USER   = 6;
  localparam logic [ORD_W-1:0]  NOT_HEAD      = 6'd63;
  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 48'h90_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC     = 2'd0,
    FUNC_FREE      = 2'd1,
    FUNC_FREE_USER = 2'd2,
    FUNC_NOP       = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_BLOCK  = 3'd1,
    ST_BAD_ORDER = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_A_UNRD, S_A_UNWR, S_A_SPLT, S_PUSH1, S_PUSH2,
    S_F_CHK, S_R_INIT, S_R_CHK, S_R_CMP, S_R_MRG2, S_S_RD, S_S_CHK, S_DONE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LOAD, OP_DISP, OP_A_UNRD, OP_UNL_WR, OP_SPLIT, OP_A_FIN,
    OP_PUSH1, OP_PUSH2, OP_F_BAD, OP_F_OK, OP_R_INIT, OP_R_RDB, OP_R_MRG1,
    OP_R_MRG2, OP_R_END, OP_S_RD, OP_S_HIT, OP_S_MISS, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  order_bad;
    logic  list_found;
    logic  addr_bad;
    logic  frame_bad;
    logic  at_top;
    logic  bud_mergeable;
    logic  split_more;
    logic  scan_done;
    logic  scan_hit;
    logic  clr_last;
    logic  out_free;
  } dp_status_t;

endpackage

[hdl/bpa_ctrl.sv]
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t stat_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.op = OP_DISP;
        unique case (stat_i.func)
          FUNC_ALLOC: begin
            if (stat_i.order_bad || !stat_i.list_found) state_d = S_DONE;
            else state_d = S_A_UNRD;
          end
          FUNC_FREE: begin
            if (stat_i.addr_bad) state_d = S_DONE;
            else state_d = S_F_CHK;
          end
          FUNC_FREE_USER: state_d = S_S_RD;
          default:        state_d = S_DONE;
        endcase
      end
      S_A_UNRD: begin
        cmd_o.op = OP_A_UNRD;
        state_d  = S_A_UNWR;
      end
      S_A_UNWR: begin
        cmd_o.op = OP_UNL_WR;
        state_d  = S_A_SPLT;
      end
      S_A_SPLT: begin
        if (stat_i.split_more) begin
          cmd_o.op = OP_SPLIT;
          state_d  = S_PUSH1;
        end else begin
          cmd_o.op = OP_A_FIN;
          state_d  = S_DONE;
        end
      end
      S_PUSH1: begin
        cmd_o.op = OP_PUSH1;
        state_d  = S_PUSH2;
      end
      S_PUSH2: begin
        cmd_o.op = OP_PUSH2;
        unique case (stat_i.func)
          FUNC_ALLOC:     state_d = S_A_SPLT;
          FUNC_FREE_USER: state_d = S_S_RD;
          default:        state_d = S_DONE;
        endcase
      end
      S_F_CHK: begin
        if (stat_i.frame_bad) begin
          cmd_o.op = OP_F_BAD;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_F_OK;
          state_d  = S_R_INIT;
        end
      end
      S_R_INIT: begin
        cmd_o.op = OP_R_INIT;
        state_d  = S_R_CHK;
      end
      S_R_CHK: begin
        if (stat_i.at_top) begin
          cmd_o.op = OP_R_END;
          state_d  = S_PUSH1;
        end else begin
          cmd_o.op = OP_R_RDB;
          state_d  = S_R_CMP;
        end
      end
      S_R_CMP: begin
        if (stat_i.bud_mergeable) begin
          cmd_o.op = OP_R_MRG1;
          state_d  = S_R_MRG2;
        end else begin
          cmd_o.op = OP_R_END;
          state_d  = S_PUSH1;
        end
      end
      S_R_MRG2: begin
        cmd_o.op = OP_R_MRG2;
        state_d  = S_R_CHK;
      end
      S_S_RD: begin
        if (stat_i.scan_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_S_RD;
          state_d  = S_S_CHK;
        end
      end
      S_S_CHK: begin
        if (stat_i.scan_hit) begin
          cmd_o.op = OP_S_HIT;
          state_d  = S_R_INIT;
        end else begin
          cmd_o.op = OP_S_MISS;
          state_d  = S_S_RD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hdl/bpa_dp.sv]
`timescale 1ns / 1ps
module bpa_dp import bpa_pkg::*; #(
  parameter int unsigned ORDER_MAX = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [ORD_W-1:0]  order_i,
  input  logic              user_flag_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] block_address_o,
  output logic [STAT_W-1:0] status_o,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        stat_o
);

  localparam int unsigned FW = ORDER_MAX;
  localparam int unsigned NF = 1 << ORDER_MAX;
  localparam int unsigned NL = ORDER_MAX + 1;
  localparam int unsigned HW = (NL > 1) ? $clog2(NL) : 1;
  localparam int unsigned HI_LO = ORDER_MAX + PAGE_SHIFT;
  localparam logic [ORD_W-1:0] OMAX = ORD_W'(ORDER_MAX);

  // frame metadata and link words; link words carry a valid bit on top
  logic [INFO_W-1:0] fi_mem [NF];
  logic [FW:0]       nx_mem [NF];
  logic [FW:0]       pv_mem [NF];

  logic [INFO_W-1:0] fi_rd_q;
  logic [FW:0]       nx_rd_q, pv_rd_q;

  logic              fi_we, fi_re, nx_we, nx_re, pv_we;
  logic [FW-1:0]     fi_wa, fi_ra, nx_wa, nx_ra, pv_wa;
  logic [INFO_W-1:0] fi_wd;
  logic [FW:0]       nx_wd, pv_wd;

  logic [ADDR_W-1:0] base_q, base_d, addr_q, addr_d;
  func_e             func_q, func_d;
  logic [ORD_W-1:0]  req_q, req_d, ord_q, ord_d;
  logic              user_q, user_d;
  logic [FW-1:0]     idx_q, idx_d, pb_q, pb_d, clr_q, clr_d;
  logic [FW:0]       scan_q, scan_d;
  logic [ADDR_W-1:0] result_q, result_d, out_addr_q, out_addr_d;
  status_e           sts_q, sts_d, out_sts_q, out_sts_d;
  logic              out_valid_q, out_valid_d;
  logic [FW-1:0]     head_q [NL];
  logic [FW-1:0]     head_d [NL];
  logic [NL-1:0]     hok_q, hok_d;

  logic [ADDR_W-1:0] off;
  logic              addr_bad, found;
  logic [ORD_W-1:0]  found_ord;
  logic [FW-1:0]     off_idx, bud, split_bud, lo_idx, hi_idx;
  logic [HW-1:0]     hsel;
  logic [ORD_W-1:0]  rd_ord;

  assign off      = addr_q - base_q;
  assign addr_bad = (addr_q < base_q) || (off[ADDR_W-1:HI_LO] != '0)
                    || (off[PAGE_SHIFT-1:0] != '0);
  assign off_idx  = off[HI_LO-1:PAGE_SHIFT];
  assign hsel     = ord_q[HW-1:0];
  assign bud       = idx_q ^ (FW'(1) << ord_q);
  assign split_bud = idx_q ^ (FW'(1) << (ord_q - ORD_W'(1)));
  assign lo_idx    = (bud < idx_q) ? bud : idx_q;
  assign hi_idx    = (bud < idx_q) ? idx_q : bud;
  assign rd_ord    = fi_rd_q[ORD_W-1:0];

  // lowest non-empty list at or above the request
  always_comb begin
    found     = 1'b0;
    found_ord = '0;
    for (int k = NL - 1; k >= 0; k--) begin
      if (hok_q[k] && (ORD_W'(k) >= req_q)) begin
        found     = 1'b1;
        found_ord = ORD_W'(k);
      end
    end
  end

  always_comb begin
    stat_o.func          = func_q;
    stat_o.order_bad     = req_q > OMAX;
    stat_o.list_found    = found;
    stat_o.addr_bad      = addr_bad;
    stat_o.frame_bad     = !fi_rd_q[BIT_ALLOC] || (rd_ord > OMAX);
    stat_o.at_top        = ord_q == OMAX;
    stat_o.bud_mergeable = {fi_rd_q[BIT_ALLOC], rd_ord} == {1'b0, ord_q};
    stat_o.split_more    = ord_q > req_q;
    stat_o.scan_done     = scan_q[FW];
    stat_o.scan_hit      = fi_rd_q[BIT_ALLOC] && fi_rd_q[BIT_USER] && (rd_ord <= OMAX);
    stat_o.clr_last      = &clr_q;
    stat_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_comb begin
    base_d      = cfg_we_i ? cfg_wdata_i : base_q;
    addr_d      = addr_q;
    func_d      = func_q;
    req_d       = req_q;
    user_d      = user_q;
    ord_d       = ord_q;
    idx_d       = idx_q;
    pb_d        = pb_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    result_d    = result_q;
    sts_d       = sts_q;
    out_addr_d  = out_addr_q;
    out_sts_d   = out_sts_q;
    out_valid_d = out_valid_q && !out_ready_i;
    head_d      = head_q;
    hok_d       = hok_q;
    fi_we = 1'b0; fi_wa = idx_q; fi_wd = '0;
    fi_re = 1'b0; fi_ra = idx_q;
    nx_we = 1'b0; nx_wa = pb_q;  nx_wd = '0;
    nx_re = 1'b0; nx_ra = idx_q;
    pv_we = 1'b0; pv_wa = pb_q;  pv_wd = '0;
    case (cmd_i.op) inside
      OP_CLR: begin
        fi_we = 1'b1;
        fi_wa = clr_q;
        fi_wd = (clr_q == '0) ? {2'b00, OMAX} : {2'b00, NOT_HEAD};
        // frame zero starts listed alone, so its links are empty
        if (clr_q == '0) begin
          nx_we = 1'b1;
          nx_wa = clr_q;
          nx_wd = '0;
          pv_we = 1'b1;
          pv_wa = clr_q;
          pv_wd = '0;
        end
        clr_d = clr_q + FW'(1);
      end
      OP_LOAD: begin
        func_d = func_e'(func_i);
        req_d  = order_i;
        user_d = user_flag_i;
        addr_d = address_i;
      end
      OP_DISP: begin
        result_d = '0;
        sts_d    = ST_OK;
        scan_d   = '0;
        case (func_q)
          FUNC_ALLOC: begin
            if (req_q > OMAX) sts_d = ST_BAD_ORDER;
            else if (!found) sts_d = ST_NO_BLOCK;
            ord_d = found_ord;
            idx_d = head_q[found_ord[HW-1:0]];
          end
          FUNC_FREE: begin
            if (addr_bad) sts_d = ST_BAD_ADDR;
            idx_d = off_idx;
            fi_re = 1'b1;
            fi_ra = off_idx;
          end
          default: ;
        endcase
      end
      OP_A_UNRD: begin
        nx_re = 1'b1;
        nx_ra = idx_q;
      end
      OP_UNL_WR, OP_R_MRG2: begin
        // take the block out of its list, its links were read last cycle
        if (pv_rd_q[FW]) begin
          nx_we = 1'b1;
          nx_wa = pv_rd_q[FW-1:0];
          nx_wd = nx_rd_q;
        end else begin
          head_d[hsel] = nx_rd_q[FW-1:0];
          hok_d[hsel]  = nx_rd_q[FW];
        end
        if (nx_rd_q[FW]) begin
          pv_we = 1'b1;
          pv_wa = nx_rd_q[FW-1:0];
          pv_wd = pv_rd_q;
        end
        if (cmd_i.op == OP_R_MRG2) begin
          fi_we = 1'b1;
          fi_wa = lo_idx;
          fi_wd = {2'b00, ord_q + ORD_W'(1)};
          idx_d = lo_idx;
          ord_d = ord_q + ORD_W'(1);
        end
      end
      OP_SPLIT: begin
        ord_d = ord_q - ORD_W'(1);
        pb_d  = split_bud;
      end
      OP_A_FIN: begin
        fi_we    = 1'b1;
        fi_wa    = idx_q;
        fi_wd    = {1'b1, user_q, req_q};
        result_d = base_q + {{(ADDR_W-FW-PAGE_SHIFT){1'b0}}, idx_q, {PAGE_SHIFT{1'b0}}};
      end
      OP_PUSH1: begin
        fi_we = 1'b1;
        fi_wa = pb_q;
        fi_wd = {2'b00, ord_q};
        nx_we = 1'b1;
        nx_wa = pb_q;
        nx_wd = {hok_q[hsel], head_q[hsel]};
        pv_we = 1'b1;
        pv_wa = pb_q;
        pv_wd = '0;
      end
      OP_PUSH2: begin
        if (hok_q[hsel]) begin
          pv_we = 1'b1;
          pv_wa = head_q[hsel];
          pv_wd = {1'b1, pb_q};
        end
        head_d[hsel] = pb_q;
        hok_d[hsel]  = 1'b1;
      end
      OP_F_BAD: sts_d = ST_NOT_ALLOC;
      OP_F_OK:  ord_d = rd_ord;
      OP_R_INIT: begin
        fi_we = 1'b1;
        fi_wa = idx_q;
        fi_wd = {2'b00, ord_q};
      end
      OP_R_RDB: begin
        fi_re = 1'b1;
        fi_ra = bud;
      end
      OP_R_MRG1: begin
        // the higher buddy stops being a block head
        fi_we = 1'b1;
        fi_wa = hi_idx;
        fi_wd = {2'b00, NOT_HEAD};
        nx_re = 1'b1;
        nx_ra = bud;
      end
      OP_R_END: pb_d = idx_q;
      OP_S_RD: begin
        fi_re = 1'b1;
        fi_ra = scan_q[FW-1:0];
      end
      OP_S_HIT: begin
        idx_d  = scan_q[FW-1:0];
        ord_d  = rd_ord;
        scan_d = scan_q + ((FW+1)'(1) << rd_ord);
      end
      OP_S_MISS: scan_d = scan_q + (FW+1)'(1);
      OP_OUT: begin
        out_valid_d = 1'b1;
        out_addr_d  = result_q;
        out_sts_d   = sts_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fi_we) fi_mem[fi_wa] <= fi_wd;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (fi_re) fi_rd_q <= fi_mem[fi_ra];
    if (nx_re) begin
      nx_rd_q <= nx_mem[nx_ra];
      pv_rd_q <= pv_mem[nx_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= HEAP_BASE_RST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NL; k++) begin
        head_q[k] <= '0;
        hok_q[k]  <= (k == NL - 1);
      end
    end else begin
      base_q      <= base_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      hok_q       <= hok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    func_q     <= func_d;
    req_q      <= req_d;
    user_q     <= user_d;
    ord_q      <= ord_d;
    idx_q      <= idx_d;
    pb_q       <= pb_d;
    scan_q     <= scan_d;
    result_q   <= result_d;
    sts_q      <= sts_d;
    out_addr_q <= out_addr_d;
    out_sts_q  <= out_sts_d;
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign status_o        = out_sts_q;

`ifndef ASSERT_OFF
  a_push_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_PUSH2 |-> $past(cmd_i.op) == OP_PUSH1)
    else $error("push second half without first half");
  a_merge_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_R_MRG2 |-> $past(cmd_i.op) == OP_R_MRG1)
    else $error("merge unlink without link read");
  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_OUT |-> (!out_valid_q || out_ready_i))
    else $error("result word overwrites a pending word");
  a_alloc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_A_FIN |-> (sts_q == ST_OK && req_q <= OMAX))
    else $error("allocation finished on a rejected request");
`endif

endmodule

[hdl/buddy_page_allocator_core.sv]
`timescale 1ns / 1ps
// allocate unlinks the found block, then splits it and pushes each upper half;
// free checks the frame, merges free buddies up to the top order, pushes the block;
// free-all frees each user block; one word in flight at a time, taken only when idle
// reset: asynchronous, then a clearing pass over all 2^ORDER_MAX metadata entries,
// during which no input word is taken; configuration writes are taken as ever
module buddy_page_allocator_core import bpa_pkg::*; #(
  parameter int unsigned ORDER_MAX = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [ORD_W-1:0]  order_i,
  input  logic              user_flag_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] block_address_o,
  output logic [STAT_W-1:0] status_o
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_dp #(
    .ORDER_MAX (ORDER_MAX)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .order_i         (order_i),
    .user_flag_i     (user_flag_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .block_address_o (block_address_o),
    .status_o        (status_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
